[design/tmvc_pkg.sv]
// shared types, operation codes and constants of the text mode cursor engine
package tmvc_pkg;

    // default screen geometry
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_TTY    = 3'd0;
    localparam logic [2:0] KIND_SET    = 3'd1;
    localparam logic [2:0] KIND_GET    = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;
    localparam logic [2:0] KIND_REPEAT = 3'd5;
    localparam logic [2:0] KIND_BLINK  = 3'd6;

    // teletype control characters
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [7:0] BLINK_BIT  = 8'h80;
    localparam logic [7:0] RESET_ATTR = 8'h0F;
    localparam logic [7:0] SHAPE_BASE = 8'd14;
    localparam logic [7:0] SHAPE_SPAN = 8'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  char_code;
        logic [7:0]  attr_in;
        logic [7:0]  col_in;
        logic [7:0]  row_in;
        logic [15:0] repeat_count;
    } t_req;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [7:0] shape_start;
        logic [7:0] shape_end;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the incoming request
        logic exec;       // single-cycle action of the latched request
        logic sweep;      // write one cell of the fill sweep
        logic init_fill;  // sweep after reset fills with zero attribute
        logic rep_step;   // one cell of a repeated write
        logic load_out;   // load the response register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       rep_zero;
        logic       rep_done;
        logic       sweep_last;
    } t_stat;

endpackage

[design/tmvc_stream_if.sv]
// valid/ready channel carrying one request or response payload
interface tmvc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/tmvc_ctrl.sv]
// controller state machine of the text mode cursor engine
module tmvc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tmvc_pkg::t_stat i_stat,
    output tmvc_pkg::t_cmd  o_cmd
);
    import tmvc_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_REP   = 3'd4;
    localparam logic [2:0] ST_POST  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.init_fill = 1'b1;
                if (i_stat.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.kind == KIND_CLEAR) begin
                    n_state = ST_CLEAR;
                end else if (i_stat.kind == KIND_READ) begin
                    n_state = ST_POST;
                end else if (i_stat.kind == KIND_REPEAT && !i_stat.rep_zero) begin
                    n_state = ST_REP;
                end else if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_POST;
                end
            end
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    if (slot_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_REP: begin
                o_cmd.rep_step = 1'b1;
                if (i_stat.rep_done) begin
                    if (slot_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_POST: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)  n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/tmvc_datapath.sv]
// cursor, attribute, screen memory and response register
module tmvc_datapath #(
    parameter int SCREEN_COLS = tmvc_pkg::DEFAULT_COLS,
    parameter int SCREEN_ROWS = tmvc_pkg::DEFAULT_ROWS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tmvc_pkg::t_req  i_req,
    input  tmvc_pkg::t_cmd  i_cmd,
    output tmvc_pkg::t_stat o_stat,
    output tmvc_pkg::t_rsp  o_rsp
);
    import tmvc_pkg::*;

    localparam int COL_W     = $clog2(SCREEN_COLS);
    localparam int ROW_W     = $clog2(SCREEN_ROWS);
    localparam int NUM_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W    = $clog2(NUM_CELLS);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NUM_CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);

    // latched request
    logic [2:0]  r_kind;
    logic [7:0]  r_char, r_attr_in, r_col_in, r_row_in;
    logic [15:0] r_count;

    // architectural state
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [7:0]        r_cur_attr, n_cur_attr;
    logic [ADDR_W-1:0] r_sweep;

    logic [15:0] r_mem [NUM_CELLS];
    logic [15:0] r_rdata;

    logic [ADDR_W-1:0] cur_addr, mem_addr;
    logic [15:0]       mem_wdata;
    logic              mem_we, printable;
    logic [7:0]        row8, shape_start;
    t_rsp              rsp_d;
    t_rsp              r_rsp;

    assign cur_addr  = ADDR_W'(ADDR_W'(r_row) * COLS_A) + ADDR_W'(r_col);
    assign printable = (r_char != CH_LF) && (r_char != CH_CR) && (r_char != CH_BS);

    // next cursor and attribute
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_cur_attr = r_cur_attr;
        if (i_cmd.exec) begin
            unique case (r_kind)
                KIND_TTY: begin
                    priority if (r_char == CH_LF) begin
                        n_row = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
                    end else if (r_char == CH_CR) begin
                        n_col = '0;
                    end else if (r_char == CH_BS) begin
                        if (r_col != '0) n_col = r_col - 1'b1;
                    end else if (r_col == LAST_COL) begin
                        // wrap to next line, no scroll past the bottom
                        n_col = '0;
                        if (r_row != LAST_ROW) n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                KIND_SET: begin
                    n_col = (r_col_in < 8'(SCREEN_COLS)) ? COL_W'(r_col_in) : LAST_COL;
                    n_row = (r_row_in < 8'(SCREEN_ROWS)) ? ROW_W'(r_row_in) : LAST_ROW;
                end
                KIND_BLINK: n_cur_attr = r_cur_attr ^ BLINK_BIT;
                default: ;
            endcase
        end
        if (i_cmd.rep_step && r_col != LAST_COL) n_col = r_col + 1'b1;
    end

    // memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = cur_addr;
        mem_wdata = {r_cur_attr, r_char};
        if (i_cmd.sweep) begin
            mem_we    = 1'b1;
            mem_addr  = r_sweep;
            mem_wdata = {(i_cmd.init_fill ? 8'h00 : r_attr_in), 8'h00};
        end else if (i_cmd.rep_step) begin
            mem_we    = 1'b1;
            mem_wdata = {r_attr_in, r_char};
        end else if (i_cmd.exec && r_kind == KIND_TTY && printable) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (i_cmd.exec) r_rdata <= r_mem[cur_addr];
    end

    // response fields
    assign row8        = 8'(r_row);
    assign shape_start = 8'(row8 << 4) + SHAPE_BASE;

    always_comb begin
        rsp_d            = '0;
        rsp_d.cursor_col = 7'(n_col);
        rsp_d.cursor_row = 5'(n_row);
        if (r_kind == KIND_READ) begin
            rsp_d.cell_char = r_rdata[7:0];
            rsp_d.cell_attr = r_rdata[15:8];
        end
        if (r_kind == KIND_GET) begin
            rsp_d.shape_start = shape_start;
            rsp_d.shape_end   = shape_start + SHAPE_SPAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_req.kind;
            r_char    <= i_req.char_code;
            r_attr_in <= i_req.attr_in;
            r_col_in  <= i_req.col_in;
            r_row_in  <= i_req.row_in;
            r_count   <= i_req.repeat_count;
        end else if (i_cmd.rep_step) begin
            r_count <= r_count - 1'b1;
        end
        if (i_cmd.load_out) r_rsp <= rsp_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_cur_attr <= RESET_ATTR;
            r_sweep    <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_cur_attr <= n_cur_attr;
            if (i_cmd.sweep) r_sweep <= (r_sweep == LAST_CELL) ? '0 : r_sweep + 1'b1;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.rep_zero   = (r_count == '0);
    assign o_stat.rep_done   = (r_col == LAST_COL) || (r_count == 16'd1);
    assign o_stat.sweep_last = (r_sweep == LAST_CELL);
    assign o_rsp             = r_rsp;

endmodule

[design/text_mode_video_cursor_engine.sv]
// top level of the text mode cursor engine
// Text-mode screen engine: a SCREEN_COLS x SCREEN_ROWS buffer of 16-bit cells
// (character in the low byte, attribute in the high byte), a cursor and a
// current attribute that resets to 0x0F. Every request returns exactly one
// response carrying the cursor after the operation, plus the cell under the
// cursor for read cell and the cursor shape for get cursor. After reset the
// block sweeps the screen memory to zero, one cell per cycle, through all
// SCREEN_COLS*SCREEN_ROWS cells (2000 at 80x25); no request is taken during
// the sweep. The block works on one request at a time. Teletype, set cursor,
// get cursor, blink toggle and the unused code are accepted, then executed
// with the response loaded; read cell adds a step after execution because
// the screen memory read is registered; repeated write adds one memory write
// per cell for N cells, where N is min(count, SCREEN_COLS - column); clear
// sweeps every cell through the same single write port. A
// response that is not yet taken holds in the output register; the next
// request is accepted meanwhile and finishes once that register frees up.
module text_mode_video_cursor_engine #(
    parameter int SCREEN_COLS = tmvc_pkg::DEFAULT_COLS,
    parameter int SCREEN_ROWS = tmvc_pkg::DEFAULT_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tmvc_stream_if.sink          i_req,
    tmvc_stream_if.source        o_rsp
);
    import tmvc_pkg::*;

    // command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;
    t_rsp  rsp;
    logic  in_ready, out_valid;

    tmvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // cursor, attribute, screen memory and response register
    tmvc_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.payload),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (rsp)
    );

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = rsp;

endmodule

[design/tmvc_checker.sv]
// port-level assertions of the text mode cursor engine and their bind
module tmvc_checker #(
    parameter int SCREEN_COLS = tmvc_pkg::DEFAULT_COLS,
    parameter int SCREEN_ROWS = tmvc_pkg::DEFAULT_ROWS
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input tmvc_pkg::t_rsp i_rsp
);
    import tmvc_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one executes");

    // a fresh response is produced only while no request is being taken
    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response appeared without execution");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (32'(i_rsp.cursor_col) < SCREEN_COLS)
                     && ((SCREEN_ROWS > 32) || (32'(i_rsp.cursor_row) < SCREEN_ROWS)))
        else $error("cursor outside the screen");

endmodule

bind text_mode_video_cursor_engine tmvc_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tmvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

[test/tb_text_mode_video_cursor_engine.sv]
// self-checking testbench of the text mode cursor engine
`timescale 1ns / 100ps

module tb_text_mode_video_cursor_engine;
    import tmvc_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    // kind 7 has no operation behind it
    localparam logic [2:0] KIND_NONE = 3'd7;
    localparam int ITEMS_PER_PHASE = 225;
    // the receiver holds off once, after this many responses
    localparam int HOLD_AT_RSP = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    // reset sweep, ~900 requests with stalls and long repeats, a few clears,
    // then a wide margin on top
    localparam int TIMEOUT_NS = 10_000_000;

    // shadow of the screen, cursor and attribute, plus the queue of responses
    // that the engine still owes
    class screen_tracker;
        int          col;
        int          row;
        logic [7:0]  cur_attr;
        logic [15:0] cells [COLS*ROWS];
        t_rsp        rsp_due [$];
        int          errors;

        function new();
            col = 0;
            row = 0;
            cur_attr = RESET_ATTR;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void put_cell(logic [7:0] ch, logic [7:0] attr);
            cells[row*COLS + col] = {attr, ch};
        endfunction

        function void teletype(logic [7:0] ch);
            if (ch == CH_LF) begin
                row++;
                if (row >= ROWS) row = 0;
            end else if (ch == CH_CR) begin
                col = 0;
            end else if (ch == CH_BS) begin
                if (col > 0) col--;
            end else begin
                put_cell(ch, cur_attr);
                col++;
                // end of line: next line, but never past the last one
                if (col >= COLS) begin
                    col = 0;
                    row++;
                    if (row >= ROWS) row = ROWS - 1;
                end
            end
        endfunction

        function t_rsp apply_request(t_req r);
            t_rsp res;
            int   left;
            res = '0;
            case (r.kind)
                KIND_TTY: begin
                    teletype(r.char_code);
                end
                KIND_SET: begin
                    col = (r.col_in < COLS) ? int'(r.col_in) : COLS - 1;
                    row = (r.row_in < ROWS) ? int'(r.row_in) : ROWS - 1;
                end
                KIND_GET: begin
                    res.shape_start = 8'(row * 16 + SHAPE_BASE);
                    res.shape_end   = res.shape_start + SHAPE_SPAN;
                end
                KIND_CLEAR: begin
                    foreach (cells[i]) cells[i] = {r.attr_in, 8'h00};
                end
                KIND_READ: begin
                    {res.cell_attr, res.cell_char} = cells[row*COLS + col];
                end
                KIND_REPEAT: begin
                    // writes run right from the cursor and stop at the last column
                    left = int'(r.repeat_count);
                    while (left > 0) begin
                        put_cell(r.char_code, r.attr_in);
                        left--;
                        if (col + 1 >= COLS) break;
                        col++;
                    end
                end
                KIND_BLINK: begin
                    cur_attr ^= BLINK_BIT;
                end
                default: begin
                end
            endcase
            res.cursor_col = 7'(col);
            res.cursor_row = 5'(row);
            return res;
        endfunction

        function void note_request(t_req r);
            rsp_due.push_back(apply_request(r));
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= 100)
                $display("error: %s got %0h expected %0h", what, got, want);
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            if (rsp_due.size() == 0) begin
                report("response with no request outstanding, cursor_col",
                       16'(got.cursor_col), '0);
                return;
            end
            want = rsp_due.pop_front();
            if (got.cursor_col != want.cursor_col)
                report("cursor_col", 16'(got.cursor_col), 16'(want.cursor_col));
            if (got.cursor_row != want.cursor_row)
                report("cursor_row", 16'(got.cursor_row), 16'(want.cursor_row));
            if (got.cell_char != want.cell_char)
                report("cell_char", 16'(got.cell_char), 16'(want.cell_char));
            if (got.cell_attr != want.cell_attr)
                report("cell_attr", 16'(got.cell_attr), 16'(want.cell_attr));
            if (got.shape_start != want.shape_start)
                report("shape_start", 16'(got.shape_start), 16'(want.shape_start));
            if (got.shape_end != want.shape_end)
                report("shape_end", 16'(got.shape_end), 16'(want.shape_end));
        endtask

        task flag_leftover();
            if (rsp_due.size() != 0)
                report("responses never returned", 16'(rsp_due.size()), '0);
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    tmvc_stream_if #(.T(t_req)) req_if ();
    tmvc_stream_if #(.T(t_rsp)) rsp_if ();

    text_mode_video_cursor_engine #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    screen_tracker tracker = new();

    // idle odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rsp_taken      = 0;
    int hold_left      = 0;

    function automatic t_req make_req(logic [2:0] kind, logic [7:0] ch, logic [7:0] attr,
                                      logic [7:0] col, logic [7:0] row, logic [15:0] cnt);
        t_req r;
        r.kind         = kind;
        r.char_code    = ch;
        r.attr_in      = attr;
        r.col_in       = col;
        r.row_in       = row;
        r.repeat_count = cnt;
        return r;
    endfunction

    // random request: mostly text output and reads back, cursor moves mostly
    // in range, repeat counts mostly short, clears rare since each walks the screen
    function automatic t_req random_req();
        t_req r;
        int   pick;
        r.kind         = KIND_NONE;
        r.char_code    = 8'($urandom_range(0, 255));
        r.attr_in      = 8'($urandom_range(0, 255));
        r.col_in       = 8'($urandom_range(0, 255));
        r.row_in       = 8'($urandom_range(0, 255));
        r.repeat_count = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 199);
        if (pick < 80) begin
            r.kind = KIND_TTY;
            // control characters often enough to move the cursor around
            case ($urandom_range(0, 11))
                0:       r.char_code = CH_LF;
                1:       r.char_code = CH_CR;
                2:       r.char_code = CH_BS;
                default: ;
            endcase
        end else if (pick < 104) begin
            r.kind = KIND_SET;
            if ($urandom_range(0, 99) < 85) begin
                r.col_in = 8'($urandom_range(0, COLS - 1));
                r.row_in = 8'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 118) begin
            r.kind = KIND_GET;
        end else if (pick < 148) begin
            r.kind = KIND_READ;
        end else if (pick < 178) begin
            r.kind = KIND_REPEAT;
            case ($urandom_range(0, 9))
                0:       ;
                1, 2, 3: r.repeat_count = 16'($urandom_range(0, 100));
                default: r.repeat_count = 16'($urandom_range(0, 12));
            endcase
        end else if (pick < 188) begin
            r.kind = KIND_BLINK;
        end else if (pick < 195) begin
            r.kind = KIND_NONE;
        end else if (pick < 197) begin
            r.kind = KIND_CLEAR;
        end else begin
            r.kind = KIND_READ;
        end
        return r;
    endfunction

    // offer one request after a random idle gap, return once it is taken
    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.note_request(r);
    endtask

    // sender goes quiet until every outstanding response is back
    task automatic wait_all_responses();
        req_if.valid <= 1'b0;
        while (tracker.rsp_due.size() != 0) @(posedge i_clk);
    endtask

    // response side: sample at the edge, then pick ready for the next cycle
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                tracker.check_response(rsp_if.payload);
                rsp_taken++;
                // one long hold-off while the sender keeps pushing, so the
                // output register fills and the engine stops taking requests
                if (rsp_taken == HOLD_AT_RSP) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int ph;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; the first request also waits out the reset sweep
        send_req(make_req(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000)); // swept cell
        send_req(make_req(KIND_GET,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'hFF, 8'hFF, 16'h0000)); // saturate
        send_req(make_req(KIND_GET,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000)); // shape wraps
        // character in the bottom right corner: cursor stays on the last row
        send_req(make_req(KIND_TTY,    8'h41, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'd79, 8'd24, 16'h0000));
        send_req(make_req(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_TTY,    CH_LF, 8'h00, 8'h00, 8'h00, 16'h0000)); // row wraps
        send_req(make_req(KIND_TTY,    CH_CR, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_TTY,    CH_BS, 8'h00, 8'h00, 8'h00, 16'h0000)); // at column 0
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'd80, 8'd25, 16'h0000)); // just past edge
        send_req(make_req(KIND_TTY,    CH_BS, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_BLINK,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_TTY,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'd78, 8'd24, 16'h0000));
        send_req(make_req(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000)); // blink attr
        send_req(make_req(KIND_BLINK,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_REPEAT, 8'h33, 8'h44, 8'h00, 8'h00, 16'h0000)); // no cells
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'd70, 8'd3,  16'h0000));
        // huge count clipped at the last column
        send_req(make_req(KIND_REPEAT, 8'h5A, 8'hA5, 8'h00, 8'h00, 16'hFFFF));
        send_req(make_req(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_CLEAR,  8'h00, 8'hFF, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_req(make_req(KIND_NONE,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(make_req(KIND_SET,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        wait_all_responses();

        // random phases: no idling, sender idle, receiver stalling, both lightly
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 8 : 0;
            repeat (ITEMS_PER_PHASE) send_req(random_req());
            wait_all_responses();
        end

        // nothing more may show up after the last response
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.flag_leftover();
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
